// ===== src/pid_speed_controller_unit_assert.svh =====
// Assertion macros for the PID speed controller.
`ifndef PID_SPEED_CONTROLLER_UNIT_ASSERT_SVH
`define PID_SPEED_CONTROLLER_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define PSC_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("psc assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define PSC_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("psc assertion failed");

// Same-cycle implication.
`define PSC_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("psc assertion failed");

`endif

// ===== src/psc_pkg.sv =====
// Shared types and constants for the PID speed controller.
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned SPEED_W    = 13;
	localparam int unsigned ERR_W      = 14;
	localparam int unsigned INTEG_W    = 32;
	localparam int unsigned CTL_W      = 41;
	localparam int unsigned DUTY_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 3'd4;

	localparam logic [7:0]  RST_PROP_GAIN   = 8'd15;
	localparam logic [7:0]  RST_INTEG_GAIN  = 8'd5;
	localparam logic [7:0]  RST_DERIV_GAIN  = 8'd5;
	localparam logic [15:0] RST_INTEG_LIMIT = 16'd1000;
	localparam logic [15:0] RST_PWM_PERIOD  = 16'd2400;

	typedef struct packed {
		logic [7:0]  prop_gain;
		logic [7:0]  integ_gain;
		logic [7:0]  deriv_gain;
		logic [15:0] integ_limit;
		logic [15:0] pwm_period;
	} cfg_t;

endpackage

`default_nettype wire

// ===== src/pid_speed_controller_unit.sv =====
// A sample word is registered in the s1 stage and its result word in the s2 stage.
// Throughput: one sample word per cycle unless the result side stalls; the control law is one registered pass.
// A waiting result word does not block a new sample; a sample stalls only
// when both registers are full and the result word is stalled.
// Reset: gains, limit and period return to defaults; integral and error clear.
`timescale 1ns / 1ps
`default_nettype none

`include "pid_speed_controller_unit_assert.svh"

module pid_speed_controller_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               sample_valid,
	output logic                                    sample_stall,
	input  wire logic signed [psc_pkg::SPEED_W-1:0] target_speed,
	input  wire logic signed [psc_pkg::SPEED_W-1:0] measured_speed,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output logic signed [psc_pkg::CTL_W-1:0]        control_raw,
	output logic        [psc_pkg::DUTY_W-1:0]       pwm_duty,
	input  wire logic                               cfg_we,
	input  wire logic [psc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [psc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import psc_pkg::*;

	cfg_t cfg;

	logic                      valid_s1;
	logic signed [SPEED_W-1:0] target_s1;
	logic signed [SPEED_W-1:0] measured_s1;
	logic                      valid_s2;
	logic signed [CTL_W-1:0]   control_s2;
	logic        [DUTY_W-1:0]  duty_s2;

	logic                      advance;
	logic                      take;
	logic signed [CTL_W-1:0]   control;
	logic        [DUTY_W-1:0]  duty;
	logic                      in_range;

	psc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	psc_law u_law (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.target_s1   (target_s1),
		.measured_s1 (measured_s1),
		.cfg         (cfg),
		.control     (control),
		.duty        (duty)
	);

	assign advance      = valid_s1 && (!valid_s2 || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign take         = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			target_s1   <= target_speed;
			measured_s1 <= measured_speed;
		end
		if (advance) begin
			control_s2 <= control;
			duty_s2    <= duty;
		end
	end

	assign result_valid = valid_s2;
	assign control_raw  = control_s2;
	assign pwm_duty     = duty_s2;

	assign in_range = !control_raw[CTL_W-1] && control_raw <= $signed({25'd0, cfg.pwm_period});

	`PSC_ASSERT_IMPL(a_empty_never_stalls, !valid_s1, !sample_stall)
	`PSC_ASSERT_NEXT(a_advance_fills_result, advance, result_valid)
	`PSC_ASSERT_IMPL(a_negative_duty_zero, result_valid && control_raw[CTL_W-1], pwm_duty == '0)
	`PSC_ASSERT_IMPL(a_in_range_duty, result_valid && in_range, pwm_duty == control_raw[DUTY_W-1:0])

endmodule

`default_nettype wire

// ===== src/psc_cfg_regs.sv =====
// Configuration register file for the PID speed controller.
`timescale 1ns / 1ps
`default_nettype none

module psc_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [psc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output psc_pkg::cfg_t                        cfg
);
	import psc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= RST_PROP_GAIN;
			cfg_q.integ_gain  <= RST_INTEG_GAIN;
			cfg_q.deriv_gain  <= RST_DERIV_GAIN;
			cfg_q.integ_limit <= RST_INTEG_LIMIT;
			cfg_q.pwm_period  <= RST_PWM_PERIOD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data[7:0];
				REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data[7:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_data[7:0];
				REG_INTEG_LIMIT: cfg_q.integ_limit <= cfg_data;
				REG_PWM_PERIOD:  cfg_q.pwm_period  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== src/psc_law.sv =====
// PID control law: error, clamped integral, derivative, output and duty.
`timescale 1ns / 1ps
`default_nettype none

module psc_law (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               advance,
	input  wire logic signed [psc_pkg::SPEED_W-1:0] target_s1,
	input  wire logic signed [psc_pkg::SPEED_W-1:0] measured_s1,
	input  wire psc_pkg::cfg_t                      cfg,
	output logic signed [psc_pkg::CTL_W-1:0]        control,
	output logic        [psc_pkg::DUTY_W-1:0]       duty
);
	import psc_pkg::*;

	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   prev_err_q;

	logic signed [ERR_W-1:0]   err;
	logic signed [INTEG_W:0]   acc_raw;
	logic signed [INTEG_W:0]   lim;
	logic signed [INTEG_W:0]   neg_lim;
	logic signed [INTEG_W-1:0] acc;
	logic signed [ERR_W:0]     der;
	logic signed [22:0]        p_term;
	logic signed [CTL_W-1:0]   i_term;
	logic signed [23:0]        d_term;
	logic signed [CTL_W-1:0]   period_ext;

	assign err     = {target_s1[SPEED_W-1], target_s1} - {measured_s1[SPEED_W-1], measured_s1};
	assign acc_raw = {integ_q[INTEG_W-1], integ_q} + {{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};
	assign lim     = $signed({17'd0, cfg.integ_limit});
	assign neg_lim = -lim;

	always_comb begin
		if (cfg.integ_limit != 16'd0) begin
			if (acc_raw > lim) begin
				acc = lim[INTEG_W-1:0];
			end else if (acc_raw < neg_lim) begin
				acc = neg_lim[INTEG_W-1:0];
			end else begin
				acc = acc_raw[INTEG_W-1:0];
			end
		end else begin
			// 32-bit saturation when the clamp is off
			if (acc_raw[INTEG_W] != acc_raw[INTEG_W-1]) begin
				acc = {acc_raw[INTEG_W], {(INTEG_W-1){~acc_raw[INTEG_W]}}};
			end else begin
				acc = acc_raw[INTEG_W-1:0];
			end
		end
	end

	assign der    = {err[ERR_W-1], err} - {prev_err_q[ERR_W-1], prev_err_q};
	assign p_term = $signed({1'b0, cfg.prop_gain}) * err;
	assign i_term = $signed({1'b0, cfg.integ_gain}) * acc;
	assign d_term = $signed({1'b0, cfg.deriv_gain}) * der;

	assign control = {{(CTL_W-23){p_term[22]}}, p_term} + i_term
		+ {{(CTL_W-24){d_term[23]}}, d_term};

	assign period_ext = $signed({25'd0, cfg.pwm_period});

	always_comb begin
		if (control > period_ext) begin
			duty = cfg.pwm_period - 16'd1;
		end else if (control[CTL_W-1]) begin
			duty = '0;
		end else begin
			duty = control[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_err_q <= '0;
		end else if (advance) begin
			integ_q    <= acc;
			prev_err_q <= err;
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_pid_speed_controller_unit.sv =====
// Self-checking testbench for the PID speed controller: predicts each result word and checks it.
`timescale 1ns / 1ps

module tb_pid_speed_controller_unit;
	import psc_pkg::*;

	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 100_000;
	localparam int SAT_RUN = 20;
	localparam int HOLD_CYCLES = 150;

	typedef struct packed {
		logic signed [CTL_W-1:0] control;
		logic [DUTY_W-1:0]       duty;
	} pid_word_t;

	class pid_ledger;
		cfg_t        regs;
		longint      integ_sum;
		longint      last_err;
		pid_word_t   words_due[$];
		int unsigned mismatches;

		function new();
			regs = '{prop_gain: RST_PROP_GAIN, integ_gain: RST_INTEG_GAIN,
				deriv_gain: RST_DERIV_GAIN, integ_limit: RST_INTEG_LIMIT,
				pwm_period: RST_PWM_PERIOD};
			integ_sum = 0;
			last_err = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PROP_GAIN: regs.prop_gain = data[7:0];
				REG_INTEG_GAIN: regs.integ_gain = data[7:0];
				REG_DERIV_GAIN: regs.deriv_gain = data[7:0];
				REG_INTEG_LIMIT: regs.integ_limit = data;
				REG_PWM_PERIOD: regs.pwm_period = data;
				default: ;
			endcase
		endfunction

		// one control step: error, clamped integral, derivative, PID sum, duty
		function void take_sample(logic signed [SPEED_W-1:0] tgt,
			logic signed [SPEED_W-1:0] mea);
			longint    err;
			longint    acc;
			longint    der;
			longint    ctl;
			longint    lim;
			pid_word_t w;
			err = longint'(tgt) - longint'(mea);
			acc = integ_sum + err;
			if (regs.integ_limit != '0) begin
				lim = longint'(regs.integ_limit);
				if (acc > lim)
					acc = lim;
				else if (acc < -lim)
					acc = -lim;
			end else begin
				if (acc > SUM_MAX)
					acc = SUM_MAX;
				else if (acc < SUM_MIN)
					acc = SUM_MIN;
			end
			integ_sum = acc;
			der = err - last_err;
			last_err = err;
			ctl = longint'(regs.prop_gain) * err + longint'(regs.integ_gain) * acc
				+ longint'(regs.deriv_gain) * der;
			if (ctl > longint'(regs.pwm_period))
				w.duty = regs.pwm_period - 16'd1;
			else if (ctl < 0)
				w.duty = '0;
			else
				w.duty = ctl[DUTY_W-1:0];
			w.control = ctl[CTL_W-1:0];
			words_due.push_back(w);
		endfunction

		function void match_output(logic signed [CTL_W-1:0] control, logic [DUTY_W-1:0] duty);
			pid_word_t w;
			if (words_due.size() == 0) begin
				$error("unexpected result word: control_raw %0d pwm_duty %0d", control, duty);
				mismatches++;
				return;
			end
			w = words_due.pop_front();
			if (control !== w.control) begin
				$error("control_raw: expected %0d, got %0d", w.control, control);
				mismatches++;
			end
			if (duty !== w.duty) begin
				$error("pwm_duty: expected %0d, got %0d", w.duty, duty);
				mismatches++;
			end
		endfunction

		function int backlog();
			return words_due.size();
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        sample_valid = 1'b0;
	logic                        sample_stall;
	logic signed [SPEED_W-1:0]   target_speed = '0;
	logic signed [SPEED_W-1:0]   measured_speed = '0;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	logic signed [CTL_W-1:0]     control_raw;
	logic [DUTY_W-1:0]           pwm_duty;
	logic                        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;

	pid_ledger ledger = new();
	bit        calm = 1'b0;
	bit        hold_wanted = 1'b0;
	int        hold_left = 0;
	int        cycle_count = 0;

	pid_speed_controller_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.target_speed(target_speed),
		.measured_speed(measured_speed),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.control_raw(control_raw),
		.pwm_duty(pwm_duty),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: check accepted words, random stalls, one long hold-off
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			ledger.match_output(control_raw, pwm_duty);
		if (hold_wanted) begin
			hold_wanted = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !calm && ($urandom_range(99) < 29);
		end
	end

	task automatic send_sample(input logic signed [SPEED_W-1:0] tgt,
		input logic signed [SPEED_W-1:0] mea);
		sample_valid <= 1'b1;
		target_speed <= tgt;
		measured_speed <= mea;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		ledger.take_sample(tgt, mea);
	endtask

	task automatic sample_gap();
		while (!calm && $urandom_range(99) < 29) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_random_sample();
		logic signed [SPEED_W-1:0] tgt;
		logic signed [SPEED_W-1:0] mea;
		tgt = SPEED_W'($urandom);
		mea = SPEED_W'($urandom);
		case ($urandom_range(9))
			6, 7, 8: mea = tgt + SPEED_W'($urandom_range(0, 40)) - SPEED_W'(20);
			9: begin
				tgt = $urandom_range(1) ? 13'sd4095 : -13'sd4096;
				mea = $urandom_range(1) ? -13'sd4096 : 13'sd4095;
			end
			default: ;
		endcase
		sample_gap();
		send_sample(tgt, mea);
	endtask

	// let every expected word come back before touching the registers
	task automatic drain();
		sample_valid <= 1'b0;
		while (ledger.backlog() > 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		ledger.write_reg(idx, data);
	endtask

	task automatic apply_settings(input cfg_t s);
		write_reg(REG_PROP_GAIN, {8'd0, s.prop_gain});
		write_reg(REG_INTEG_GAIN, {8'd0, s.integ_gain});
		write_reg(REG_DERIV_GAIN, {8'd0, s.deriv_gain});
		write_reg(REG_INTEG_LIMIT, s.integ_limit);
		write_reg(REG_PWM_PERIOD, s.pwm_period);
		cfg_we <= 1'b0;
	endtask

	function automatic cfg_t pick_settings();
		cfg_t s;
		s.prop_gain = 8'($urandom);
		s.integ_gain = 8'($urandom);
		s.deriv_gain = 8'($urandom);
		case ($urandom_range(3))
			0: s.integ_limit = '0;
			1: s.integ_limit = 16'($urandom_range(1, 50));
			2: s.integ_limit = 16'($urandom_range(1, 65535));
			default: s.integ_limit = 16'hFFFF;
		endcase
		if ($urandom_range(1))
			s.pwm_period = 16'($urandom_range(1, 65535));
		else
			s.pwm_period = 16'($urandom_range(1, 300));
		return s;
	endfunction

	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: field extremes, clamp at both ends of the limit
		send_sample(13'sd0, 13'sd0);
		send_sample(13'sd4095, -13'sd4096);
		send_sample(13'sd4095, -13'sd4096);
		send_sample(-13'sd4096, 13'sd4095);
		send_sample(-13'sd4096, 13'sd4095);
		send_sample(-13'sd1, -13'sd1);
		send_sample(13'sd4095, 13'sd4095);
		send_sample(-13'sd4096, -13'sd4096);
		send_sample(13'sd1, 13'sd0);
		send_sample(13'sd0, 13'sd1);
		send_sample(13'sd4095, -13'sd4096);
		drain();

		// pure proportional, limit cut to one: duty at, above and below the period
		apply_settings('{prop_gain: 8'd1, integ_gain: 8'd0, deriv_gain: 8'd0,
			integ_limit: 16'd1, pwm_period: 16'd100});
		send_sample(13'sd100, 13'sd0);
		send_sample(13'sd101, 13'sd0);
		send_sample(13'sd99, 13'sd0);
		send_sample(13'sd0, 13'sd1);
		send_sample(13'sd0, 13'sd0);
		drain();

		apply_settings('{prop_gain: 8'd255, integ_gain: 8'd255, deriv_gain: 8'd255,
			integ_limit: 16'hFFFF, pwm_period: 16'hFFFF});
		repeat (150)
			send_random_sample();
		drain();

		apply_settings('{prop_gain: 8'd0, integ_gain: 8'd0, deriv_gain: 8'd0,
			integ_limit: 16'd0, pwm_period: 16'd1});
		repeat (100)
			send_random_sample();
		drain();

		apply_settings('{prop_gain: 8'd255, integ_gain: 8'd255, deriv_gain: 8'd255,
			integ_limit: 16'd0, pwm_period: 16'd1});
		repeat (100)
			send_random_sample();
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			apply_settings(pick_settings());
			if (ph == 4) begin
				calm = 1'b1;
				hold_wanted = 1'b1;
			end
			repeat (150)
				send_random_sample();
			calm = 1'b0;
			drain();
		end

		// no limit, full gains: integral runs free at the largest error, then back off
		apply_settings('{prop_gain: 8'd255, integ_gain: 8'd255, deriv_gain: 8'd255,
			integ_limit: 16'd0, pwm_period: 16'hFFFF});
		calm = 1'b1;
		repeat (SAT_RUN)
			send_sample(13'sd4095, -13'sd4096);
		calm = 1'b0;
		repeat (20)
			send_random_sample();
		drain();

		repeat (8)
			@(posedge clk);
		if (ledger.mismatches == 0 && ledger.backlog() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
